@@ sv/erp_pkg.sv @@
// Shared types, codes and constants of the encoder readout and publish controller.
`default_nettype none
package erp_pkg;

	// Event kinds on the input stream
	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_SPI   = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Result kinds on the output stream
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_SPI   = 2'd1;
	localparam logic [1:0] ACT_FRAME = 2'd2;

	// Configuration register indexes
	localparam logic REG_NODE_ID = 1'b0;
	localparam logic REG_TICKS   = 1'b1;

	// Encoder protocol bytes
	localparam logic [7:0] SPI_READ_POS = 8'h10;
	localparam logic [7:0] SPI_NOP      = 8'h00;
	localparam logic [7:0] SPI_WAIT     = 8'hA5;

	// Command payload bytes
	localparam logic [7:0] BYTE_CMD_RUN  = 8'h01;
	localparam logic [7:0] BYTE_CMD_STOP = 8'h02;
	localparam logic [7:0] BYTE_SUB_ONE  = 8'h01;
	localparam logic [7:0] BYTE_SUB_TWO  = 8'h02;

	localparam logic [10:0] CMD_ID_OFFSET = 11'd384;
	localparam logic [10:0] NODE_ID_RST   = 11'd498;
	localparam logic [7:0]  TICKS_RST     = 8'd1;

	// 360 degrees in 1/512 degree units
	localparam int unsigned ANGLE_SCALE = 184320;
	localparam logic [21:0] ANGLE_MAX   = 22'h3FFFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [10:0] frame_id;
		logic [63:0] frame_payload;
		logic [7:0]  spi_in;
	} erp_item_t;

	// Decision of the control stage, before the angle is worked out
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  spi_out;
		logic [10:0] out_id;
		logic [15:0] position_raw;
	} erp_res_t;

endpackage
`default_nettype wire

@@ sv/erp_ctrl.sv @@
// Input register and readout control: command decode, SPI handshake, publish timing.
`default_nettype none
module erp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  erp_pkg::erp_item_t  in_item,
	input  wire [10:0]          node_id,
	input  wire [7:0]           ticks_per_unit,
	output logic                out_valid,
	input  wire                 out_ready,
	output erp_pkg::erp_res_t   out_res
);
	import erp_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_CONT   = 2'd1,
		MODE_SINGLE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		PH_NONE = 3'd0,
		PH_CMD  = 3'd1,
		PH_SYNC = 3'd2,
		PH_HIGH = 3'd3,
		PH_LOW  = 3'd4
	} phase_t;

	logic       v_s1;
	erp_item_t  item_s1;
	logic       v_s2;
	erp_res_t   res_s2;
	logic       en_s1;
	logic       en_s2;

	mode_t      mode_q,     mode_d;
	phase_t     phase_q,    phase_d;
	logic       stop_q,     stop_d;
	logic [7:0] interval_q, interval_d;
	logic [15:0] wait_q,    wait_d;
	logic [7:0] high_q,     high_d;
	erp_res_t   res_d;

	logic       id_hit;
	logic [7:0] b0, b1, b2;
	logic       tail3_zero, tail2_zero;
	logic       is_stop, is_start, is_poll;
	logic [16:0] wait_prod;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign b0 = item_s1.frame_payload[7:0];
	assign b1 = item_s1.frame_payload[15:8];
	assign b2 = item_s1.frame_payload[23:16];
	assign tail3_zero = (item_s1.frame_payload[63:24] == 40'd0);
	assign tail2_zero = (item_s1.frame_payload[63:16] == 48'd0);
	assign id_hit = (node_id >= CMD_ID_OFFSET) && (item_s1.frame_id == node_id - CMD_ID_OFFSET);
	assign is_stop  = (b0 == BYTE_CMD_STOP) && (b1 == BYTE_SUB_ONE) && tail3_zero;
	assign is_start = (b0 == BYTE_CMD_RUN) && (b1 == BYTE_SUB_ONE) && tail3_zero;
	assign is_poll  = (b0 == BYTE_CMD_RUN) && (b1 == BYTE_SUB_TWO) && tail2_zero;
	assign wait_prod = ({1'b0, interval_q} + 9'd1) * ticks_per_unit;

	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		stop_d     = stop_q;
		interval_d = interval_q;
		wait_d     = wait_q;
		high_d     = high_q;
		res_d      = '0;
		case (item_s1.cmd)
			CMD_FRAME: begin
				if (id_hit) begin
					if (is_stop) begin
						if (mode_q == MODE_CONT) begin
							if (phase_q == PH_NONE) begin
								mode_d = MODE_IDLE;
								wait_d = '0;
								stop_d = 1'b0;
							end else begin
								stop_d = 1'b1;
							end
						end
					end else if (mode_q == MODE_IDLE) begin
						if (is_start) begin
							interval_d    = b2;
							mode_d        = MODE_CONT;
							stop_d        = 1'b0;
							phase_d       = PH_CMD;
							res_d.action  = ACT_SPI;
							res_d.spi_out = SPI_READ_POS;
						end else if (is_poll) begin
							mode_d        = MODE_SINGLE;
							phase_d       = PH_CMD;
							res_d.action  = ACT_SPI;
							res_d.spi_out = SPI_READ_POS;
						end
					end
				end
			end
			CMD_SPI: begin
				case (phase_q)
					PH_CMD: begin
						phase_d       = PH_SYNC;
						res_d.action  = ACT_SPI;
						res_d.spi_out = SPI_NOP;
					end
					PH_SYNC: begin
						// keep polling while the encoder still answers with the wait byte
						if (item_s1.spi_in != SPI_WAIT) begin
							phase_d = PH_HIGH;
						end
						res_d.action  = ACT_SPI;
						res_d.spi_out = SPI_NOP;
					end
					PH_HIGH: begin
						high_d        = item_s1.spi_in;
						phase_d       = PH_LOW;
						res_d.action  = ACT_SPI;
						res_d.spi_out = SPI_NOP;
					end
					PH_LOW: begin
						res_d.action       = ACT_FRAME;
						res_d.out_id       = node_id;
						res_d.position_raw = {high_q, item_s1.spi_in};
						phase_d            = PH_NONE;
						if (mode_q == MODE_CONT && !stop_q) begin
							wait_d = wait_prod[15:0];
						end else begin
							mode_d = MODE_IDLE;
							stop_d = 1'b0;
							wait_d = '0;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_TICK: begin
				if (mode_q == MODE_CONT && phase_q == PH_NONE) begin
					if (wait_q <= 16'd1) begin
						wait_d        = '0;
						phase_d       = PH_CMD;
						res_d.action  = ACT_SPI;
						res_d.spi_out = SPI_READ_POS;
					end else begin
						wait_d = wait_q - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_q    <= PH_NONE;
			stop_q     <= 1'b0;
			interval_q <= '0;
			wait_q     <= '0;
			high_q     <= '0;
			v_s2       <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				mode_q     <= mode_d;
				phase_q    <= phase_d;
				stop_q     <= stop_d;
				interval_q <= interval_d;
				wait_q     <= wait_d;
				high_q     <= high_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = v_s2;
	assign out_res   = res_s2;

endmodule
`default_nettype wire

@@ sv/erp_angle.sv @@
// Angle pipeline: position * 184320 / COUNTS_PER_REV by split multiply and reciprocal.
`default_nettype none
module erp_angle #(
	parameter int unsigned COUNTS_PER_REV = 4096
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  erp_pkg::erp_res_t   in_res,
	output logic                out_valid,
	input  wire                 out_ready,
	output erp_pkg::erp_res_t   out_res,
	output logic [21:0]         angle_fixed
);
	import erp_pkg::*;

	// scale = A * COUNTS_PER_REV + B, so angle = pos * A + floor(pos * B / COUNTS_PER_REV)
	localparam int unsigned      A_INT = ANGLE_SCALE / COUNTS_PER_REV;
	localparam int unsigned      B_INT = ANGLE_SCALE % COUNTS_PER_REV;
	localparam longint unsigned  M_INT = 64'h1_0000_0000 / COUNTS_PER_REV;
	localparam logic [9:0]  A_V = A_INT[9:0];
	localparam logic [15:0] B_V = B_INT[15:0];
	localparam logic [24:0] M_V = M_INT[24:0];
	localparam logic [16:0] C_V = 17'(COUNTS_PER_REV);

	logic        v_s3, v_s4, v_s5;
	logic        en_s3, en_s4, en_s5;
	erp_res_t    res_s3, res_s4, res_s5;
	logic [31:0] x_s3, x_s4;
	logic [25:0] pa_s3, pa_s4;
	logic [15:0] q_s4;
	logic [21:0] ang_s5;

	logic [56:0] qm_prod;
	logic [32:0] qc_prod;
	logic [32:0] rem;
	logic [16:0] q_fix;
	logic [26:0] sum;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign qm_prod = x_s3 * M_V;
	assign qc_prod = q_s4 * C_V;
	assign rem     = {1'b0, x_s4} - qc_prod;
	// the reciprocal estimate is low by at most one
	assign q_fix   = {1'b0, q_s4} + ((rem >= {16'd0, C_V}) ? 17'd1 : 17'd0);
	assign sum     = {1'b0, pa_s4} + {10'd0, q_fix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			res_s3 <= in_res;
			x_s3   <= in_res.position_raw * B_V;
			pa_s3  <= in_res.position_raw * A_V;
		end
		if (en_s4 && v_s3) begin
			res_s4 <= res_s3;
			x_s4   <= x_s3;
			pa_s4  <= pa_s3;
			q_s4   <= qm_prod[47:32];
		end
		if (en_s5 && v_s4) begin
			res_s5 <= res_s4;
			ang_s5 <= (sum > {5'd0, ANGLE_MAX}) ? ANGLE_MAX : sum[21:0];
		end
	end

	assign out_valid   = v_s5;
	assign out_res     = res_s5;
	assign angle_fixed = ang_s5;

endmodule
`default_nettype wire

@@ sv/encoder_readout_publish_controller_core.sv @@
// Top level of the encoder readout and publish controller: ports, configuration, stages.
//
// Channel   Direction  Beat contents
// s_*       in         tuser: cmd; tdata: frame_id, frame_payload, spi_in
// m_*       out        tuser: action; tdata: spi_out, out_id, angle_fixed, position_raw
// cfg_*     in         write enable, register index, write data
//
// One beat in gives one beat out; one beat per cycle sustained while m_tready stays high.
// The control stage decides on the registered input beat; the angle takes three more stages (split multiply,
// reciprocal multiply, correction), the last of which is the output register.
// Reset clears stage valids, readout state and configuration to its reset values.
// A stall on m_tready fills any empty stages first; s_tready drops once every stage holds a beat.
`default_nettype none
module encoder_readout_publish_controller_core #(
	parameter int unsigned COUNTS_PER_REV = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [87:0] s_tdata,   // frame_id[10:0], frame_payload[74:11], spi_in[82:75]
	input  wire  [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // spi_out[7:0], out_id[18:8], angle_fixed[40:19],
	                               // position_raw[56:41]
	output logic [1:0]  m_tuser,   // action[1:0]
	input  wire         cfg_we,
	input  wire         cfg_idx,
	input  wire  [10:0] cfg_data
);
	import erp_pkg::*;

	logic [10:0] node_id_q;
	logic [7:0]  ticks_q;
	erp_item_t   item;
	logic        ctl_valid;
	logic        ang_ready;
	erp_res_t    ctl_res;
	erp_res_t    out_res;
	logic [21:0] angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= NODE_ID_RST;
			ticks_q   <= TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NODE_ID: node_id_q <= cfg_data;
				REG_TICKS:   ticks_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// cmd, frame_id, frame_payload, spi_in from the top bit down
	assign item = {s_tuser, s_tdata[10:0], s_tdata[74:11], s_tdata[82:75]};

	erp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_item        (item),
		.node_id        (node_id_q),
		.ticks_per_unit (ticks_q),
		.out_valid      (ctl_valid),
		.out_ready      (ang_ready),
		.out_res        (ctl_res)
	);

	erp_angle #(
		.COUNTS_PER_REV (COUNTS_PER_REV)
	) u_angle (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (ctl_valid),
		.in_ready    (ang_ready),
		.in_res      (ctl_res),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (out_res),
		.angle_fixed (angle)
	);

	assign m_tuser = out_res.action;
	assign m_tdata = {7'd0, out_res.position_raw, angle, out_res.out_id, out_res.spi_out};

endmodule
`default_nettype wire
